/* hw/rtl/sgenc_pkg.sv */
// Shared types and state codes for the segment sort gap encoder.
// Used by sgenc_cell and segment_sort_gap_encoder_top; no dependencies.
`default_nettype none
package sgenc_pkg;

  localparam int WORD_W = 32;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              final_req;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic              run_end;
    logic              overflowed;
  } out_t;

  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctl_t;

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

endpackage
`default_nettype wire

/* hw/rtl/sgenc_cell.sv */
// One cell of the insertion sorting chain: holds one word of the segment.
// Depends on sgenc_pkg for the word width and the control struct.
`default_nettype none
module sgenc_cell
  import sgenc_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctl_t         ctl,
  input  wire logic [WORD_W-1:0] ins_word,
  input  wire logic              occupied,
  input  wire logic [WORD_W-1:0] left_val,
  input  wire logic              left_greater,
  input  wire logic [WORD_W-1:0] right_val,
  output logic      [WORD_W-1:0] val,
  output logic                   greater
);

  assign greater = occupied && (val > ins_word);

  always_ff @(posedge clk) begin
    if (ctl.shl) begin
      val <= right_val;
    end else if (ctl.ins && (!occupied || greater)) begin
      val <= left_greater ? left_val : ins_word;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/segment_sort_gap_encoder_top.sv */
// Top level of the segment sort gap encoder: a chain of sgenc_cell sorting
// nonzero words on arrival, and a drain sequencer emitting first value and gaps.
// Depends on sgenc_pkg and sgenc_cell.
//
//   channel | signals                          | payload
//   --------+----------------------------------+-------------------------
//   input   | in_valid, in_stall, in_data      | in_t  (word, final_req)
//   output  | out_valid, out_stall, out_data   | out_t (code, run_end, overflowed)
//
// While loading, one word is taken every cycle; the cell chain inserts it in order
// in that cycle. At a segment end the buffered words drain from the head of the
// chain, one output word per cycle, then a zero separator if the segment was
// closed by one; the input is stalled meanwhile. Output stall holds the drain.
// Synchronous reset clears count, ovf, sep, out_valid and the sequencer at once.
`default_nettype none
module segment_sort_gap_encoder_top
  import sgenc_pkg::*;
#(
  parameter int MAX_SEGMENT = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam int CW = $clog2(MAX_SEGMENT + 1);

  logic              state;
  logic [CW-1:0]     count;
  logic              ovf;
  logic              sep;
  logic [WORD_W-1:0] prev;

  logic              in_fire;
  logic              is_sep;
  logic              has_room;
  logic              out_free;
  logic              load_out;
  out_t              out_next;
  cell_ctl_t         ctl;

  logic [WORD_W-1:0] vals [MAX_SEGMENT];
  logic              grt  [MAX_SEGMENT];

  assign in_stall = (state != ST_LOAD);
  assign in_fire  = in_valid && !in_stall;
  assign is_sep   = (in_data.word == '0);
  assign has_room = (count < CW'(MAX_SEGMENT));
  assign out_free = !out_valid || !out_stall;

  assign ctl.ins = in_fire && !is_sep && has_room;
  assign ctl.shl = (state == ST_DRAIN) && out_free && (count != '0);

  for (genvar i = 0; i < MAX_SEGMENT; i++) begin : g_cell
    logic [WORD_W-1:0] left_v;
    logic              left_g;
    logic [WORD_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_v = vals[i-1];
      assign left_g = grt[i-1];
    end

    if (i == MAX_SEGMENT - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_inner
      assign right_v = vals[i+1];
    end

    sgenc_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .ins_word     (in_data.word),
      .occupied     (count > CW'(i)),
      .left_val     (left_v),
      .left_greater (left_g),
      .right_val    (right_v),
      .val          (vals[i]),
      .greater      (grt[i])
    );
  end

  always_comb begin
    load_out = 1'b0;
    out_next = '0;
    if ((state == ST_DRAIN) && out_free) begin
      if (count != '0) begin
        load_out            = 1'b1;
        out_next.code       = vals[0] - prev;
        out_next.run_end    = (count == CW'(1)) && !sep;
        out_next.overflowed = ovf;
      end else if (sep) begin
        load_out            = 1'b1;
        out_next.code       = '0;
        out_next.run_end    = 1'b1;
        out_next.overflowed = ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      sep       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (!is_sep) begin
              if (has_room) begin
                count <= count + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end
            if (is_sep || in_data.final_req) begin
              state <= ST_DRAIN;
              sep   <= is_sep;
            end
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            if (count != '0) begin
              out_valid <= 1'b1;
              count     <= count - CW'(1);
            end else if (sep) begin
              out_valid <= 1'b1;
              sep       <= 1'b0;
            end else begin
              state <= ST_LOAD;
              ovf   <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
    if (in_fire) begin
      prev <= '0;
    end else if (ctl.shl) begin
      prev <= vals[0];
    end
  end

endmodule
`default_nettype wire
